// ----- hw/rtl/tsyn_pkg.sv -----
package tsyn_pkg;

	// frame geometry
	localparam int FRAME_BYTES = 54;
	localparam int FRAME_BITS  = FRAME_BYTES * 8;
	localparam int IDX_W       = $clog2(FRAME_BYTES);

	// configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	// field widths
	localparam int MAC_W   = 48;
	localparam int IPV4_W  = 32;
	localparam int PORT_W  = 16;
	localparam int TICK_W  = 24;
	localparam int SEQ_W   = 32;
	localparam int IPSUM_W = 19;
	localparam int TCPSUM_W = 20;

	localparam logic [TICK_W-1:0] INTERVAL_RESET = 24'd1000;

	// fixed header fields
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [15:0] IP_VER_IHL_TOS = 16'h4500;
	localparam logic [15:0] IP_TOTAL_LEN   = 16'd40;
	localparam logic [15:0] IP_ID          = 16'd54321;
	localparam logic [15:0] IP_FRAG        = 16'h0000;
	localparam logic [7:0]  IP_TTL         = 8'd64;
	localparam logic [7:0]  IP_PROTO_TCP   = 8'd6;
	localparam logic [15:0] TCP_OFF_FLAGS  = 16'h5002;
	localparam logic [15:0] TCP_WINDOW     = 16'd5840;
	localparam logic [15:0] TCP_LEN        = 16'd20;

	// constant parts of the two ones-complement sums
	localparam int IP_SUM_BASE = int'(IP_VER_IHL_TOS) + int'(IP_TOTAL_LEN) + int'(IP_ID)
		+ int'(IP_FRAG) + int'({IP_TTL, IP_PROTO_TCP});
	localparam int TCP_SUM_BASE = int'(IP_PROTO_TCP) + int'(TCP_LEN) + int'(TCP_OFF_FLAGS)
		+ int'(TCP_WINDOW);

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_MAC,
		REG_DEST_MAC,
		REG_SOURCE_IPV4,
		REG_DEST_IPV4,
		REG_SOURCE_PORT,
		REG_DEST_PORT,
		REG_INTERVAL_TICKS
	} cfg_reg_t;

	typedef struct packed {
		logic [MAC_W-1:0]  source_mac;
		logic [MAC_W-1:0]  dest_mac;
		logic [IPV4_W-1:0] source_ipv4;
		logic [IPV4_W-1:0] dest_ipv4;
		logic [PORT_W-1:0] source_port;
		logic [PORT_W-1:0] dest_port;
		logic [TICK_W-1:0] interval_ticks;
	} cfg_regs_t;

	// frame request from the scheduler to the serializer
	typedef struct packed {
		logic [SEQ_W-1:0]    seq;
		logic [IPSUM_W-1:0]  ip_sum;
		logic [TCPSUM_W-1:0] tcp_sum;
	} frame_req_t;

endpackage

// ----- hw/rtl/tsyn_tick_if.sv -----
interface tsyn_tick_if;
	logic valid;
	logic ready;
	logic run_enable;

	modport source (output valid, output run_enable, input ready);
	modport sink (input valid, input run_enable, output ready);
endinterface

// ----- hw/rtl/tsyn_frame_if.sv -----
interface tsyn_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_last;

	modport source (output valid, output frame_byte, output frame_last, input ready);
	modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

// ----- hw/rtl/tsyn_cfg_if.sv -----
interface tsyn_cfg_if;
	import tsyn_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/tsyn_cfg.sv -----
module tsyn_cfg (
	input  logic                clk,
	input  logic                arst_n,
	tsyn_cfg_if.sink            cfg,
	output tsyn_pkg::cfg_regs_t regs
);
	import tsyn_pkg::*;

	cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// register file, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '{source_mac: '0, dest_mac: '0, source_ipv4: '0, dest_ipv4: '0,
				source_port: '0, dest_port: '0, interval_ticks: INTERVAL_RESET};
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SOURCE_MAC:     regs_q.source_mac     <= cfg.data[MAC_W-1:0];
				REG_DEST_MAC:       regs_q.dest_mac       <= cfg.data[MAC_W-1:0];
				REG_SOURCE_IPV4:    regs_q.source_ipv4    <= cfg.data[IPV4_W-1:0];
				REG_DEST_IPV4:      regs_q.dest_ipv4      <= cfg.data[IPV4_W-1:0];
				REG_SOURCE_PORT:    regs_q.source_port    <= cfg.data[PORT_W-1:0];
				REG_DEST_PORT:      regs_q.dest_port      <= cfg.data[PORT_W-1:0];
				REG_INTERVAL_TICKS: regs_q.interval_ticks <= cfg.data[TICK_W-1:0];
				default: ;
			endcase
		end
	end
endmodule

// ----- hw/rtl/tsyn_sched.sv -----
module tsyn_sched (
	input  logic                 clk,
	input  logic                 arst_n,
	tsyn_tick_if.sink            tick,
	input  tsyn_pkg::cfg_regs_t  regs,
	output logic                 req_valid,
	output tsyn_pkg::frame_req_t req,
	input  logic                 req_ready
);
	import tsyn_pkg::*;

	logic [TICK_W-1:0]   ticks_q;
	logic [SEQ_W-1:0]    seq_q;
	logic                req_valid_s1;
	frame_req_t          req_s1;
	logic                accept;
	logic                send;
	logic [TICK_W-1:0]   reload;
	logic [IPSUM_W-1:0]  ip_sum;
	logic [TCPSUM_W-1:0] tcp_sum;

	// a tick with a running countdown can never send, so it needs no free slot
	assign tick.ready = !req_valid_s1 || req_ready || (ticks_q != '0);
	assign accept     = tick.valid && tick.ready;
	assign send       = accept && tick.run_enable && (ticks_q == '0);

	// zero interval behaves as one
	assign reload = (regs.interval_ticks == '0) ? '0 : regs.interval_ticks - 1'b1;

	// raw ones-complement sums, folded in the serializer
	assign ip_sum = IPSUM_W'(IP_SUM_BASE)
		+ IPSUM_W'(regs.source_ipv4[31:16]) + IPSUM_W'(regs.source_ipv4[15:0])
		+ IPSUM_W'(regs.dest_ipv4[31:16])   + IPSUM_W'(regs.dest_ipv4[15:0]);

	assign tcp_sum = TCPSUM_W'(TCP_SUM_BASE)
		+ TCPSUM_W'(regs.source_ipv4[31:16]) + TCPSUM_W'(regs.source_ipv4[15:0])
		+ TCPSUM_W'(regs.dest_ipv4[31:16])   + TCPSUM_W'(regs.dest_ipv4[15:0])
		+ TCPSUM_W'(regs.source_port)        + TCPSUM_W'(regs.dest_port)
		+ TCPSUM_W'(seq_q[31:16])            + TCPSUM_W'(seq_q[15:0]);

	// tick countdown and sequence number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= '0;
			seq_q   <= '0;
		end else if (accept) begin
			if (!tick.run_enable) begin
				ticks_q <= '0;
			end else if (ticks_q != '0) begin
				ticks_q <= ticks_q - 1'b1;
			end else begin
				ticks_q <= reload;
				seq_q   <= seq_q + 1'b1;
			end
		end
	end

	// request stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (send) begin
			req_valid_s1 <= 1'b1;
		end else if (req_ready) begin
			req_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (send) begin
			req_s1.seq     <= seq_q;
			req_s1.ip_sum  <= ip_sum;
			req_s1.tcp_sum <= tcp_sum;
		end
	end

	assign req_valid = req_valid_s1;
	assign req       = req_s1;
endmodule

// ----- hw/rtl/tsyn_ser.sv -----
module tsyn_ser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tsyn_pkg::cfg_regs_t  regs,
	input  logic                 req_valid,
	input  tsyn_pkg::frame_req_t req,
	output logic                 req_ready,
	tsyn_frame_if.source         frame
);
	import tsyn_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

	logic                  busy_q;
	logic [IDX_W-1:0]      idx_q;
	logic [SEQ_W-1:0]      seq_q;
	logic [15:0]           ipck_q;
	logic [15:0]           tcpck_q;
	logic                  out_valid_q;
	logic [7:0]            byte_q;
	logic                  last_q;
	logic                  adv;
	logic                  fin;
	logic                  load;
	logic [IDX_W-1:0]      rev;
	logic [FRAME_BITS-1:0] frame_vec;

	// end-around carry fold and complement
	function automatic logic [15:0] ones_fold(input logic [TCPSUM_W-1:0] s);
		logic [16:0] a;
		logic [16:0] b;
		a = 17'(s[15:0]) + 17'(s[TCPSUM_W-1:16]);
		b = 17'(a[15:0]) + 17'(a[16]);
		return ~b[15:0];
	endfunction

	assign adv       = busy_q && (!out_valid_q || frame.ready);
	assign fin       = adv && (idx_q == LAST_IDX);
	assign req_ready = !busy_q || fin;
	assign load      = req_valid && req_ready;

	// whole frame in wire order, first byte in the top bits
	assign frame_vec = {regs.dest_mac, regs.source_mac, ETHERTYPE_IPV4,
		IP_VER_IHL_TOS, IP_TOTAL_LEN, IP_ID, IP_FRAG, IP_TTL, IP_PROTO_TCP, ipck_q,
		regs.source_ipv4, regs.dest_ipv4,
		regs.source_port, regs.dest_port, seq_q, 32'h0000_0000,
		TCP_OFF_FLAGS, TCP_WINDOW, tcpck_q, 16'h0000};

	assign rev = LAST_IDX - idx_q;

	// frame slot and byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else begin
				if (fin) begin
					busy_q <= 1'b0;
				end
				if (adv) begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			seq_q   <= req.seq;
			ipck_q  <= ones_fold(TCPSUM_W'(req.ip_sum));
			tcpck_q <= ones_fold(req.tcp_sum);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q <= frame_vec[{rev, 3'b000} +: 8];
			last_q <= (idx_q == LAST_IDX);
		end
	end

	assign frame.valid      = out_valid_q;
	assign frame.frame_byte = byte_q;
	assign frame.frame_last = last_q;
endmodule

// ----- hw/rtl/tcp_syn_heartbeat_frame_generator_unit.sv -----
// Periodic TCP SYN frame source. Each tick transaction carries run_enable; while it
// is set, the first tick and then every interval_ticks-th tick start a 54-byte
// Ethernet/IPv4/TCP SYN frame with both checksums filled in, and the sequence number
// advances by one per frame. Ticks with a running countdown are taken one per cycle;
// any other tick waits while a frame request is held. A sending tick is held in a
// single request stage until the serializer is free; the serializer puts out one byte
// per output transaction. The first byte of a frame passes the request stage, the
// serializer's frame slot and its output register. Settings must be changed only while
// no frame is in flight; the block itself does not enforce this.
module tcp_syn_heartbeat_frame_generator_unit (
	input  logic         clk,
	input  logic         arst_n,
	tsyn_cfg_if.sink     cfg,
	tsyn_tick_if.sink    tick,
	tsyn_frame_if.source frame
);
	import tsyn_pkg::*;

	cfg_regs_t  regs;
	logic       req_valid;
	logic       req_ready;
	frame_req_t req;

	tsyn_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	tsyn_sched u_sched (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick),
		.regs      (regs),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready)
	);

	tsyn_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.regs      (regs),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready),
		.frame     (frame)
	);

	// a waiting frame request keeps its contents
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("frame request changed while stalled");

	// a stopped tick never creates a request
	a_stop_no_req: assert property (@(posedge clk) disable iff (!arst_n)
		tick.valid && tick.ready && !tick.run_enable && !req_valid |=> !req_valid)
		else $error("stopped tick produced a frame request");

	// with no request pending the tick side is open
	a_tick_open: assert property (@(posedge clk) disable iff (!arst_n)
		!req_valid |-> tick.ready)
		else $error("tick transaction refused with an empty request stage");
endmodule

// ----- tb/sv/tb_tcp_syn_heartbeat_frame_generator_unit.sv -----
module tb_tcp_syn_heartbeat_frame_generator_unit;
	import tsyn_pkg::*;

	localparam int TICK_ITEMS    = 300;
	localparam int TAIL_ITEMS    = 40;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_CYCLES    = 30;
	localparam int HOLD_CYCLES   = 300;
	localparam int HOLD_PHASE    = 3;
	localparam int LIMIT_CYCLES  = 2000000;

	// index past the last register, writes to it must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic [CFG_DATA_W-1:0] ALL_ONES = '1;

	// fixed header bytes as they appear on the wire
	localparam logic [7:0] ETH_TYPE_HI  = 8'h08;
	localparam logic [7:0] IP_VER_IHL   = 8'h45;
	localparam logic [7:0] IP_LEN_LO    = 8'd40;
	localparam logic [15:0] IP_IDENT    = 16'd54321;
	localparam logic [7:0] IP_TTL_VAL   = 8'd64;
	localparam logic [7:0] IP_PROTO_VAL = 8'd6;
	localparam logic [7:0] TCP_DOFF     = 8'h50;
	localparam logic [7:0] TCP_SYN_FLAG = 8'h02;
	localparam logic [15:0] TCP_WIN     = 16'd5840;
	localparam logic [15:0] TCP_SEG_LEN = 16'd20;

	typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t               kind;
		logic [CFG_IDX_W-1:0]    idx;
		logic [CFG_DATA_W-1:0]   data;
		logic                    run;
		logic                    typed;
		logic [7:0]              byte0;
	} stim_row_t;

	typedef struct {
		logic [7:0] frame_byte;
		logic       frame_last;
	} wire_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tsyn_cfg_if   cfg_if();
	tsyn_tick_if  tick_if();
	tsyn_frame_if frame_if();

	tcp_syn_heartbeat_frame_generator_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.tick   (tick_if),
		.frame  (frame_if)
	);

	always #5 clk = ~clk;

	// shadow of the register file and frame state
	logic [MAC_W-1:0]  smac_m;
	logic [MAC_W-1:0]  dmac_m;
	logic [IPV4_W-1:0] sip_m;
	logic [IPV4_W-1:0] dip_m;
	logic [PORT_W-1:0] sport_m;
	logic [PORT_W-1:0] dport_m;
	logic [TICK_W-1:0] ival_m;
	logic [SEQ_W-1:0]  seq_m;
	logic [TICK_W-1:0] wait_m;

	wire_byte_t wire_q[$];
	stim_row_t  dir_q[$];

	int fail_count = 0;
	int ticks_sent = 0;
	int cfg_writes = 0;
	int frames_seen = 0;
	int bytes_checked = 0;
	int phase = 0;
	int cycle_count = 0;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int stall_left = 0;
	logic tail_on = 1'b0;

	function automatic logic [15:0] fold_invert(input logic [31:0] acc);
		while (acc[31:16] != 16'd0)
			acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
		return ~acc[15:0];
	endfunction

	task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_SOURCE_MAC:     smac_m = data[MAC_W-1:0];
			REG_DEST_MAC:       dmac_m = data[MAC_W-1:0];
			REG_SOURCE_IPV4:    sip_m = data[IPV4_W-1:0];
			REG_DEST_IPV4:      dip_m = data[IPV4_W-1:0];
			REG_SOURCE_PORT:    sport_m = data[PORT_W-1:0];
			REG_DEST_PORT:      dport_m = data[PORT_W-1:0];
			REG_INTERVAL_TICKS: ival_m = data[TICK_W-1:0];
			default: ;
		endcase
	endtask

	// build one frame image and queue its bytes; a typed row pins the first byte
	task automatic queue_frame(input logic typed, input logic [7:0] byte0);
		logic [7:0] f [FRAME_BYTES];
		logic [31:0] acc;
		logic [15:0] ck;
		int i;
		for (i = 0; i < FRAME_BYTES; i++)
			f[i] = 8'h00;
		for (i = 0; i < 6; i++) begin
			f[i] = dmac_m[47-8*i -: 8];
			f[6+i] = smac_m[47-8*i -: 8];
		end
		f[12] = ETH_TYPE_HI;
		f[14] = IP_VER_IHL;
		f[17] = IP_LEN_LO;
		f[18] = IP_IDENT[15:8];
		f[19] = IP_IDENT[7:0];
		f[22] = IP_TTL_VAL;
		f[23] = IP_PROTO_VAL;
		for (i = 0; i < 4; i++) begin
			f[26+i] = sip_m[31-8*i -: 8];
			f[30+i] = dip_m[31-8*i -: 8];
			f[38+i] = seq_m[31-8*i -: 8];
		end
		// ip header checksum
		acc = 32'd0;
		for (i = 14; i < 34; i += 2)
			acc += {16'd0, f[i], f[i+1]};
		ck = fold_invert(acc);
		f[24] = ck[15:8];
		f[25] = ck[7:0];
		// tcp header
		f[34] = sport_m[15:8];
		f[35] = sport_m[7:0];
		f[36] = dport_m[15:8];
		f[37] = dport_m[7:0];
		f[46] = TCP_DOFF;
		f[47] = TCP_SYN_FLAG;
		f[48] = TCP_WIN[15:8];
		f[49] = TCP_WIN[7:0];
		// tcp checksum over pseudo header and segment
		acc = {16'd0, sip_m[31:16]} + {16'd0, sip_m[15:0]} + {16'd0, dip_m[31:16]}
			+ {16'd0, dip_m[15:0]} + {24'd0, IP_PROTO_VAL} + {16'd0, TCP_SEG_LEN};
		for (i = 34; i < FRAME_BYTES; i += 2)
			acc += {16'd0, f[i], f[i+1]};
		ck = fold_invert(acc);
		f[50] = ck[15:8];
		f[51] = ck[7:0];
		if (typed)
			f[0] = byte0;
		for (i = 0; i < FRAME_BYTES; i++)
			wire_q.push_back(wire_byte_t'{f[i], i == FRAME_BYTES - 1});
	endtask

	// tick scheduling: stop clears the countdown, zero interval acts as one
	task automatic predict_tick(input logic run, input logic typed, input logic [7:0] byte0);
		if (!run) begin
			wait_m = '0;
		end else if (wait_m != '0) begin
			wait_m = wait_m - 1'b1;
		end else begin
			queue_frame(typed, byte0);
			seq_m = seq_m + 1'b1;
			wait_m = (ival_m == '0) ? '0 : ival_m - 1'b1;
		end
	endtask

	task automatic check_byte(input logic [7:0] b, input logic l);
		wire_byte_t e;
		if (wire_q.size() == 0) begin
			fail_count++;
			$display("%0t: frame byte with nothing expected, got byte %02h last %0b", $time, b, l);
			return;
		end
		e = wire_q.pop_front();
		bytes_checked++;
		if (l)
			frames_seen++;
		if (b !== e.frame_byte) begin
			fail_count++;
			$display("%0t: frame_byte expected %02h actual %02h", $time, e.frame_byte, b);
		end
		if (l !== e.frame_last) begin
			fail_count++;
			$display("%0t: frame_last expected %0b actual %0b", $time, e.frame_last, l);
		end
	endtask

	// tick transaction, valid stays up for a following one
	task automatic send_tick(input logic run, input logic typed, input logic [7:0] byte0);
		cfg_if.valid <= 1'b0;
		tick_if.valid <= 1'b1;
		tick_if.run_enable <= run;
		@(posedge clk);
		while (!tick_if.ready)
			@(posedge clk);
		ticks_sent++;
		predict_tick(run, typed, byte0);
	endtask

	task automatic tick_gap(input int n);
		cfg_if.valid <= 1'b0;
		tick_if.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// wait until every frame byte is out and the pipe is empty
	task automatic settle();
		cfg_if.valid <= 1'b0;
		tick_if.valid <= 1'b0;
		while (wire_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= data;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_writes++;
		apply_cfg(idx, data);
	endtask

	function automatic logic [CFG_DATA_W-1:0] rand_word();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: r = '0;
			1: r = '1;
			default: ;
		endcase
		return r[CFG_DATA_W-1:0];
	endfunction

	// mostly short intervals so frames come often, now and then zero or huge
	function automatic logic [CFG_DATA_W-1:0] rand_interval();
		logic [23:0] lo;
		logic [23:0] hi;
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 12)
			lo = 24'($urandom_range(1, 4));
		else if (pick < 14)
			lo = 24'd0;
		else if (pick < 18)
			lo = 24'($urandom_range(5, 40));
		else
			lo = 24'($urandom);
		hi = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'd0;
		return {hi, lo};
	endfunction

	// frame sink: checks each transaction, stalls in bursts, long hold on request
	always @(posedge clk) begin
		if (frame_if.valid && frame_if.ready)
			check_byte(frame_if.frame_byte, frame_if.frame_last);
		if (!arst_n) begin
			frame_if.ready <= 1'b0;
		end else if (hold_seen != hold_asks) begin
			hold_seen <= hold_asks;
			hold_left <= HOLD_CYCLES - 1;
			frame_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			frame_if.ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			frame_if.ready <= 1'b0;
		end else if (!tail_on && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(1, 19) - 1;
			frame_if.ready <= 1'b0;
		end else begin
			frame_if.ready <= 1'b1;
		end
	end

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("run stopped at cycle limit, %0d bytes still expected", wire_q.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int k;
		int r;
		int n;
		logic after_tick;
		logic gappy;

		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		tick_if.valid = 1'b0;
		tick_if.run_enable = 1'b0;

		smac_m = '0;
		dmac_m = '0;
		sip_m = '0;
		dip_m = '0;
		sport_m = '0;
		dport_m = '0;
		ival_m = 24'd1000;
		seq_m = '0;
		wait_m = '0;

		// directed rows: reset values, all-ones fields, zero and max interval,
		// stop clearing the countdown, write to the unused index
		dir_q.push_back(stim_row_t'{ROW_TICK, REG_UNUSED, '0, 1'b1, 1'b1, 8'h00});
		dir_q.push_back(stim_row_t'{ROW_TICK, REG_UNUSED, '0, 1'b1, 1'b0, 8'h00});
		dir_q.push_back(stim_row_t'{ROW_TICK, REG_UNUSED, '0, 1'b0, 1'b0, 8'h00});
		dir_q.push_back(stim_row_t'{ROW_TICK, REG_UNUSED, '0, 1'b1, 1'b1, 8'h00});
		dir_q.push_back(stim_row_t'{ROW_CFG, REG_DEST_MAC, ALL_ONES, 1'b0, 1'b0, 8'h00});
		dir_q.push_back(stim_row_t'{ROW_CFG, REG_SOURCE_MAC, ALL_ONES, 1'b0, 1'b0, 8'h00});
		dir_q.push_back(stim_row_t'{ROW_CFG, REG_SOURCE_IPV4, ALL_ONES, 1'b0, 1'b0, 8'h00});
		dir_q.push_back(stim_row_t'{ROW_CFG, REG_DEST_IPV4, ALL_ONES, 1'b0, 1'b0, 8'h00});
		dir_q.push_back(stim_row_t'{ROW_CFG, REG_SOURCE_PORT, ALL_ONES, 1'b0, 1'b0, 8'h00});
		dir_q.push_back(stim_row_t'{ROW_CFG, REG_DEST_PORT, ALL_ONES, 1'b0, 1'b0, 8'h00});
		dir_q.push_back(stim_row_t'{ROW_CFG, REG_INTERVAL_TICKS, '0, 1'b0, 1'b0, 8'h00});
		dir_q.push_back(stim_row_t'{ROW_TICK, REG_UNUSED, '0, 1'b0, 1'b0, 8'h00});
		dir_q.push_back(stim_row_t'{ROW_TICK, REG_UNUSED, '0, 1'b1, 1'b1, 8'hFF});
		dir_q.push_back(stim_row_t'{ROW_TICK, REG_UNUSED, '0, 1'b1, 1'b1, 8'hFF});
		dir_q.push_back(stim_row_t'{ROW_CFG, REG_UNUSED, ALL_ONES, 1'b0, 1'b0, 8'h00});
		dir_q.push_back(stim_row_t'{ROW_CFG, REG_DEST_MAC, 48'h8001_0203_0405, 1'b0, 1'b0, 8'h00});
		dir_q.push_back(stim_row_t'{ROW_CFG, REG_INTERVAL_TICKS, 48'd2, 1'b0, 1'b0, 8'h00});
		dir_q.push_back(stim_row_t'{ROW_TICK, REG_UNUSED, '0, 1'b1, 1'b1, 8'h80});
		dir_q.push_back(stim_row_t'{ROW_TICK, REG_UNUSED, '0, 1'b1, 1'b0, 8'h00});
		dir_q.push_back(stim_row_t'{ROW_TICK, REG_UNUSED, '0, 1'b1, 1'b1, 8'h80});
		dir_q.push_back(stim_row_t'{ROW_CFG, REG_INTERVAL_TICKS, ALL_ONES, 1'b0, 1'b0, 8'h00});
		dir_q.push_back(stim_row_t'{ROW_CFG, REG_SOURCE_IPV4, '0, 1'b0, 1'b0, 8'h00});
		dir_q.push_back(stim_row_t'{ROW_TICK, REG_UNUSED, '0, 1'b1, 1'b0, 8'h00});
		dir_q.push_back(stim_row_t'{ROW_TICK, REG_UNUSED, '0, 1'b1, 1'b0, 8'h00});
		dir_q.push_back(stim_row_t'{ROW_TICK, REG_UNUSED, '0, 1'b1, 1'b0, 8'h00});
		dir_q.push_back(stim_row_t'{ROW_TICK, REG_UNUSED, '0, 1'b0, 1'b0, 8'h00});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		after_tick = 1'b0;
		for (k = 0; k < dir_q.size(); k++) begin
			if (dir_q[k].kind == ROW_CFG) begin
				if (after_tick)
					settle();
				after_tick = 1'b0;
				cfg_write(dir_q[k].idx, dir_q[k].data);
			end else begin
				send_tick(dir_q[k].run, dir_q[k].typed, dir_q[k].byte0);
				after_tick = 1'b1;
			end
		end

		// random phases: drain, new settings, a burst of ticks
		while (ticks_sent < TICK_ITEMS) begin
			settle();
			phase++;
			if (ticks_sent >= TICK_ITEMS - TAIL_ITEMS)
				tail_on <= 1'b1;
			for (r = 0; r <= REG_INTERVAL_TICKS; r++) begin
				if ($urandom_range(0, 1) == 1)
					cfg_write(CFG_IDX_W'(r), (r == REG_INTERVAL_TICKS) ? rand_interval() : rand_word());
			end
			if ($urandom_range(0, 7) == 0)
				cfg_write(REG_UNUSED, rand_word());
			if (phase == HOLD_PHASE) begin
				// sink holds off while frames pile up behind it
				cfg_write(REG_INTERVAL_TICKS, 48'd1);
				hold_asks <= hold_asks + 1;
				repeat (12) send_tick(1'b1, 1'b0, 8'h00);
			end else begin
				n = $urandom_range(5, 25);
				gappy = ($urandom_range(0, 2) != 0) && (ticks_sent < TICK_ITEMS - TAIL_ITEMS);
				repeat (n) begin
					if (gappy && $urandom_range(0, 3) == 0)
						tick_gap($urandom_range(1, 19));
					send_tick($urandom_range(0, 9) != 0, 1'b0, 8'h00);
				end
			end
		end

		settle();
		repeat (END_CYCLES) @(posedge clk);
		$display("ran %0d ticks over %0d random phases with %0d register writes", ticks_sent,
			phase, cfg_writes);
		$display("checked %0d frame bytes in %0d frames", bytes_checked, frames_seen);
		if (fail_count == 0 && wire_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d bytes never seen", fail_count, wire_q.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- tcp_syn_heartbeat_frame_generator_unit.f -----
hw/rtl/tsyn_pkg.sv
hw/rtl/tsyn_tick_if.sv
hw/rtl/tsyn_frame_if.sv
hw/rtl/tsyn_cfg_if.sv
hw/rtl/tsyn_cfg.sv
hw/rtl/tsyn_sched.sv
hw/rtl/tsyn_ser.sv
hw/rtl/tcp_syn_heartbeat_frame_generator_unit.sv
tb/sv/tb_tcp_syn_heartbeat_frame_generator_unit.sv
